FILE: sv/assert_macros.svh
// Assertion helpers used by the qvr_chk checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define QVR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define QVR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/qvr_pkg.sv
package qvr_pkg;

  localparam int Q_W       = 16;
  localparam int IN_W      = 7 * Q_W;
  localparam int OUT_W     = 16;
  localparam int OUT_DW    = 3 * OUT_W;
  localparam int T_W       = 33;
  localparam int SS_W      = 33;
  localparam int LEN_W     = 17;
  localparam int C_W       = 17;
  localparam int N_W       = 18;
  localparam int QT_W      = 15;
  localparam int REM_W     = 32;
  localparam int SQ_W      = 34;
  localparam int SQ_ITER   = 17;
  localparam int SQ_STAGES = (SQ_ITER + 1) / 2;
  localparam int DV_STAGES = (QT_W + 1) / 2;
  localparam int NORM_SH   = 14;
  localparam int P_W       = T_W + N_W;
  localparam int R_W       = P_W + 2;
  localparam int RND_SH    = 28;
  localparam int RQ_W      = R_W - RND_SH;
  localparam int EPS_W     = 15;
  localparam int NST       = 3 + SQ_STAGES + 1 + DV_STAGES + 4;
  localparam int CAP       = NST + 2;

  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);
  localparam logic REG_LENGTH_EPSILON = 1'b0;

  typedef struct packed {
    logic [SQ_W-1:0] v;
    logic [SQ_W-1:0] r;
  } sq_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [LEN_W-1:0] den;
    logic [QT_W-1:0]  quo;
  } dv_t;

  typedef struct packed {
    logic [3:0][T_W-1:0] t;
    logic [3:0][C_W-1:0] c;
  } side_t;

  // One bit of the restoring square root, iteration it counts from the top bit.
  function automatic sq_t sqrt_step(sq_t a, int unsigned it);
    sq_t o;
    logic [SQ_W-1:0] b;
    logic [SQ_W-1:0] tr;
    b  = SQ_W'(1) << (2 * (SQ_ITER - 1 - it));
    tr = a.r + b;
    if (a.v >= tr) begin
      o.v = a.v - tr;
      o.r = (a.r >> 1) + b;
    end else begin
      o.v = a.v;
      o.r = a.r >> 1;
    end
    return o;
  endfunction

  // One quotient bit of the restoring divider, weight 2^k.
  function automatic dv_t div_step(dv_t a, int unsigned k);
    dv_t o;
    logic [REM_W-1:0] dsh;
    o   = a;
    dsh = REM_W'(a.den) << k;
    if (a.rem >= dsh) begin
      o.rem = a.rem - dsh;
      o.quo = a.quo | (QT_W'(1) << k);
    end
    return o;
  endfunction

endpackage

FILE: sv/qvr_div.sv
module qvr_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [qvr_pkg::REM_W-1:0] num_i,
  input  logic [qvr_pkg::LEN_W-1:0] den_i,
  output logic [qvr_pkg::QT_W-1:0]  quo_o
);
  import qvr_pkg::*;

  dv_t st_in [DV_STAGES];
  dv_t st_d  [DV_STAGES];
  dv_t st_q  [DV_STAGES];

  assign st_in[0] = '{rem: num_i, den: den_i, quo: '0};

  for (genvar s = 0; s < DV_STAGES; s++) begin : g_st
    if (s > 0) begin : g_link
      assign st_in[s] = st_q[s-1];
    end

    // two quotient bits per stage, top bit first
    always_comb begin
      st_d[s] = st_in[s];
      for (int j = 0; j < 2; j++) begin
        if (2 * s + j < QT_W) begin
          st_d[s] = div_step(st_d[s], QT_W - 1 - (2 * s + j));
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  assign quo_o = st_q[DV_STAGES-1].quo;

endmodule

FILE: sv/qvr_sqrt.sv
module qvr_sqrt (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [qvr_pkg::SS_W-1:0]  sumsq_i,
  output logic [qvr_pkg::LEN_W-1:0] len_o
);
  import qvr_pkg::*;

  sq_t st_in [SQ_STAGES];
  sq_t st_d  [SQ_STAGES];
  sq_t st_q  [SQ_STAGES];

  assign st_in[0] = '{v: SQ_W'(sumsq_i), r: '0};

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_st
    if (s > 0) begin : g_link
      assign st_in[s] = st_q[s-1];
    end

    always_comb begin
      st_d[s] = st_in[s];
      for (int j = 0; j < 2; j++) begin
        if (2 * s + j < SQ_ITER) begin
          st_d[s] = sqrt_step(st_d[s], 2 * s + j);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  assign len_o = st_q[SQ_STAGES-1].r[LEN_W-1:0];

endmodule

FILE: sv/quaternion_vector_rotate_core.sv
// Quaternion vector rotation: each transaction carries q and v, and the block returns
// the vector part of q*v*conj(q)/|q| in Q7.8, saturated, with too_short set when the
// integer length of q is not above length_epsilon (conjugate then used unnormalized).
// One transaction per cycle enters while s_tready is high. Most of the pipeline depth
// lies in the length square root (17 iterations, two per stage) and the normalizing
// divider (15 quotient bits, two per stage, four lanes). A two-entry output
// queue lets input continue while one result waits; with two waiting, s_tready drops
// and the whole pipeline holds. length_epsilon is sampled mid-pipeline, so write it
// only while no transaction is in flight.
module quaternion_vector_rotate_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z (16 bits each)
  input  logic [qvr_pkg::IN_W-1:0]    s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // out_x, out_y, out_z (16 bits each)
  output logic [qvr_pkg::OUT_DW-1:0]  m_tdata,
  // too_short
  output logic [0:0]                  m_tuser,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import qvr_pkg::*;

  typedef struct packed {
    side_t      sd;
    logic [3:0] neg;
    logic       is_short;
  } dside_t;

  typedef struct packed {
    logic [OUT_W-1:0] z;
    logic [OUT_W-1:0] y;
    logic [OUT_W-1:0] x;
    logic             is_short;
  } out_t;

  localparam int ST_LAST = NST - 1;

  logic en;
  logic [NST-1:0] vld_q;
  logic [EPS_W-1:0] eps_q;

  // configuration
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_LENGTH_EPSILON) begin
      eps_q <= pwdata[EPS_W-1:0];
    end
  end
  assign prdata = (paddr[2] == REG_LENGTH_EPSILON) ? 32'(eps_q) : '0;

  // valid bits travel with the data; all pipeline registers hold when en is low
  assign s_tready = en;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], s_tvalid};
    end
  end

  // input register
  logic signed [Q_W-1:0] q_q [4];
  logic signed [Q_W-1:0] v_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) q_q[i] <= s_tdata[Q_W*i +: Q_W];
      for (int i = 0; i < 3; i++) v_q[i] <= s_tdata[Q_W*(i+4) +: Q_W];
    end
  end

  // products of q*(0,v) and squares of q
  logic signed [2*Q_W-1:0] p_q [12];
  logic signed [2*Q_W-1:0] sq_q [4];
  logic signed [Q_W-1:0]   q1_q [4];
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0]  <= q_q[1] * v_q[0];
      p_q[1]  <= q_q[2] * v_q[1];
      p_q[2]  <= q_q[3] * v_q[2];
      p_q[3]  <= q_q[0] * v_q[0];
      p_q[4]  <= q_q[2] * v_q[2];
      p_q[5]  <= q_q[3] * v_q[1];
      p_q[6]  <= q_q[0] * v_q[1];
      p_q[7]  <= q_q[1] * v_q[2];
      p_q[8]  <= q_q[3] * v_q[0];
      p_q[9]  <= q_q[0] * v_q[2];
      p_q[10] <= q_q[1] * v_q[1];
      p_q[11] <= q_q[2] * v_q[0];
      for (int i = 0; i < 4; i++) begin
        sq_q[i] <= q_q[i] * q_q[i];
        q1_q[i] <= q_q[i];
      end
    end
  end

  // sums: t = q*v, |q|^2, conjugate
  logic signed [T_W-1:0] t_q [4];
  logic [SS_W-1:0]       ss_q;
  logic signed [C_W-1:0] c_q [4];
  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q[0] <= -(T_W'(p_q[0]) + T_W'(p_q[1]) + T_W'(p_q[2]));
      t_q[1] <= T_W'(p_q[3]) + T_W'(p_q[4]) - T_W'(p_q[5]);
      t_q[2] <= T_W'(p_q[6]) - T_W'(p_q[7]) + T_W'(p_q[8]);
      t_q[3] <= T_W'(p_q[9]) + T_W'(p_q[10]) - T_W'(p_q[11]);
      ss_q   <= SS_W'(unsigned'(sq_q[0])) + SS_W'(unsigned'(sq_q[1]))
              + SS_W'(unsigned'(sq_q[2])) + SS_W'(unsigned'(sq_q[3]));
      c_q[0] <= C_W'(q1_q[0]);
      for (int i = 1; i < 4; i++) c_q[i] <= -C_W'(q1_q[i]);
    end
  end

  // length square root, sideband alongside
  logic [LEN_W-1:0] len;
  side_t            sd_q [SQ_STAGES];

  qvr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .en_i    (en),
    .sumsq_i (ss_q),
    .len_o   (len)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sd_q[0].t[i] <= t_q[i];
        sd_q[0].c[i] <= c_q[i];
      end
      for (int s = 1; s < SQ_STAGES; s++) sd_q[s] <= sd_q[s-1];
    end
  end

  // normalize setup: |c|*2^14 + len/2, so the truncating divider rounds to nearest
  logic [REM_W-1:0] pr_num_q [4];
  logic [LEN_W-1:0] pr_len_q;
  dside_t           pr_q;
  always_ff @(posedge clk_i) begin
    logic [C_W-1:0] mag;
    logic           ng;
    if (en) begin
      pr_q.sd       <= sd_q[SQ_STAGES-1];
      pr_q.is_short <= len <= LEN_W'(eps_q);
      pr_len_q      <= len;
      for (int i = 0; i < 4; i++) begin
        ng  = sd_q[SQ_STAGES-1].c[i][C_W-1];
        mag = ng ? -sd_q[SQ_STAGES-1].c[i] : sd_q[SQ_STAGES-1].c[i];
        pr_q.neg[i]  <= ng;
        pr_num_q[i]  <= (REM_W'(mag) << NORM_SH) + REM_W'(len >> 1);
      end
    end
  end

  logic [QT_W-1:0] quo [4];
  dside_t          dsd_q [DV_STAGES];

  for (genvar i = 0; i < 4; i++) begin : g_div
    qvr_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (pr_num_q[i]),
      .den_i (pr_len_q),
      .quo_o (quo[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dsd_q[0] <= pr_q;
      for (int s = 1; s < DV_STAGES; s++) dsd_q[s] <= dsd_q[s-1];
    end
  end

  // normalized (or raw) conjugate
  logic [N_W-1:0]      n_q [4];
  logic [3:0][T_W-1:0] nt_q;
  logic                n_short_q;
  always_ff @(posedge clk_i) begin
    logic [N_W-1:0] qe;
    if (en) begin
      nt_q      <= dsd_q[DV_STAGES-1].sd.t;
      n_short_q <= dsd_q[DV_STAGES-1].is_short;
      for (int i = 0; i < 4; i++) begin
        qe = N_W'(quo[i]);
        if (dsd_q[DV_STAGES-1].is_short) begin
          n_q[i] <= N_W'($signed(dsd_q[DV_STAGES-1].sd.c[i]));
        end else begin
          n_q[i] <= dsd_q[DV_STAGES-1].neg[i] ? -qe : qe;
        end
      end
    end
  end

  // vector part of t*n
  logic signed [P_W-1:0] m_q [3][4];
  logic                  m_short_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_short_q <= n_short_q;
      m_q[0][0] <= $signed(nt_q[0]) * $signed(n_q[1]);
      m_q[0][1] <= $signed(nt_q[1]) * $signed(n_q[0]);
      m_q[0][2] <= $signed(nt_q[2]) * $signed(n_q[3]);
      m_q[0][3] <= $signed(nt_q[3]) * $signed(n_q[2]);
      m_q[1][0] <= $signed(nt_q[0]) * $signed(n_q[2]);
      m_q[1][1] <= $signed(nt_q[1]) * $signed(n_q[3]);
      m_q[1][2] <= $signed(nt_q[2]) * $signed(n_q[0]);
      m_q[1][3] <= $signed(nt_q[3]) * $signed(n_q[1]);
      m_q[2][0] <= $signed(nt_q[0]) * $signed(n_q[3]);
      m_q[2][1] <= $signed(nt_q[1]) * $signed(n_q[2]);
      m_q[2][2] <= $signed(nt_q[2]) * $signed(n_q[1]);
      m_q[2][3] <= $signed(nt_q[3]) * $signed(n_q[0]);
    end
  end

  logic signed [R_W-1:0] r_q [3];
  logic                  r_short_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      r_short_q <= m_short_q;
      r_q[0] <= R_W'(m_q[0][0]) + R_W'(m_q[0][1]) + R_W'(m_q[0][2]) - R_W'(m_q[0][3]);
      r_q[1] <= R_W'(m_q[1][0]) - R_W'(m_q[1][1]) + R_W'(m_q[1][2]) + R_W'(m_q[1][3]);
      r_q[2] <= R_W'(m_q[2][0]) + R_W'(m_q[2][1]) - R_W'(m_q[2][2]) + R_W'(m_q[2][3]);
    end
  end

  // round half away from zero by 2^28, then saturate
  logic [OUT_W-1:0] o_d [3];
  always_comb begin
    logic [R_W-1:0]  mag;
    logic [RQ_W-1:0] rq;
    logic            ng;
    for (int j = 0; j < 3; j++) begin
      ng  = r_q[j][R_W-1];
      mag = ng ? -r_q[j] : r_q[j];
      rq  = RQ_W'((mag + (R_W'(1) << (RND_SH - 1))) >> RND_SH);
      if (!ng && rq > RQ_W'(32767)) begin
        o_d[j] = 16'h7fff;
      end else if (ng && rq > RQ_W'(32768)) begin
        o_d[j] = 16'h8000;
      end else begin
        o_d[j] = ng ? -rq[OUT_W-1:0] : rq[OUT_W-1:0];
      end
    end
  end

  out_t o_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      o_q <= '{z: o_d[2], y: o_d[1], x: o_d[0], is_short: r_short_q};
    end
  end

  // two-entry output queue
  out_t       f_q [2];
  logic [1:0] fcnt_q;
  logic       push;
  logic       pop;

  assign en   = (fcnt_q != 2'd2);
  assign push = en && vld_q[ST_LAST];
  assign pop  = m_tvalid && m_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcnt_q <= '0;
    end else begin
      fcnt_q <= fcnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && pop) begin
      if (fcnt_q == 2'd1) begin
        f_q[0] <= o_q;
      end else begin
        f_q[0] <= f_q[1];
        f_q[1] <= o_q;
      end
    end else if (push) begin
      if (fcnt_q == 2'd0) f_q[0] <= o_q;
      else f_q[1] <= o_q;
    end else if (pop) begin
      f_q[0] <= f_q[1];
    end
  end

  assign m_tvalid = (fcnt_q != 2'd0);
  assign m_tdata  = {f_q[0].z, f_q[0].y, f_q[0].x};
  assign m_tuser  = f_q[0].is_short;

endmodule

FILE: sv/qvr_chk.sv
`include "assert_macros.svh"

module qvr_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [qvr_pkg::OUT_DW-1:0]  m_tdata,
  input logic [0:0]                  m_tuser
);
  import qvr_pkg::*;

  localparam int CW = $clog2(CAP + 1);

  // transactions accepted but not yet delivered
  logic [CW-1:0] cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + CW'(s_tvalid && s_tready) - CW'(m_tvalid && m_tready);
    end
  end

  `QVR_ASSERT(a_hold, clk_i, rst_ni, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
  `QVR_ASSERT(a_stall_cause, clk_i, rst_ni, !s_tready |-> m_tvalid, "input stalled with no result waiting")
  `QVR_ASSERT(a_no_invent, clk_i, rst_ni, m_tvalid |-> cnt_q != '0, "result with no transaction in flight")
  `QVR_ASSERT(a_cap, clk_i, rst_ni, cnt_q <= CW'(CAP), "more transactions in flight than storage")
  `QVR_ASSERT_ALWAYS(a_rst_idle, clk_i, !rst_ni |-> !m_tvalid, "result shown during reset")

endmodule

bind quaternion_vector_rotate_core qvr_chk u_qvr_chk (.*);

FILE: bench/qvr_rotation_checker.sv
`timescale 1ns / 1ps

module qvr_rotation_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [qvr_pkg::IN_W-1:0]   s_tdata,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [qvr_pkg::OUT_DW-1:0] m_tdata,
  input  logic [0:0]                 m_tuser,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  output int                         fail_count,
  output int                         pending_count,
  output int                         rotated_count,
  output int                         short_count
);
  import qvr_pkg::*;

  typedef struct packed {
    logic        short_q;
    logic [15:0] z;
    logic [15:0] y;
    logic [15:0] x;
  } rotated_t;

  rotated_t            rotated_q[$];
  logic [EPS_W-1:0]    eps_reg;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned mag, q;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = (mag + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic rotated_t rotate_vector(logic [IN_W-1:0] d, logic [EPS_W-1:0] eps);
    longint q[4], v[3], t[4], c[4], n[4], r1, r2, r3;
    longint unsigned ss, len;
    rotated_t o;
    for (int i = 0; i < 4; i++) q[i] = longint'($signed(d[16*i +: 16]));
    for (int i = 0; i < 3; i++) v[i] = longint'($signed(d[64 + 16*i +: 16]));
    t[0] = -q[1]*v[0] - q[2]*v[1] - q[3]*v[2];
    t[1] = q[0]*v[0] + q[2]*v[2] - q[3]*v[1];
    t[2] = q[0]*v[1] - q[1]*v[2] + q[3]*v[0];
    t[3] = q[0]*v[2] + q[1]*v[1] - q[2]*v[0];
    c[0] = q[0];
    c[1] = -q[1];
    c[2] = -q[2];
    c[3] = -q[3];
    ss = q[0]*q[0] + q[1]*q[1] + q[2]*q[2] + q[3]*q[3];
    len = root_floor(ss);
    o.short_q = (len <= longint'(eps));
    for (int i = 0; i < 4; i++) n[i] = o.short_q ? c[i] : round_div(c[i] * 16384, len);
    r1 = t[0]*n[1] + t[1]*n[0] + t[2]*n[3] - t[3]*n[2];
    r2 = t[0]*n[2] - t[1]*n[3] + t[2]*n[0] + t[3]*n[1];
    r3 = t[0]*n[3] + t[1]*n[2] - t[2]*n[1] + t[3]*n[0];
    o.x = clamp16(round_div(r1, 64'd1 << 28));
    o.y = clamp16(round_div(r2, 64'd1 << 28));
    o.z = clamp16(round_div(r3, 64'd1 << 28));
    return o;
  endfunction

  assign pending_count = rotated_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    rotated_t want;
    int       errs;
    errs = 0;
    if (!rst_ni) begin
      eps_reg       <= EPS_RESET;
      fail_count    <= 0;
      rotated_count <= 0;
      short_count   <= 0;
      rotated_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
        eps_reg <= pwdata[EPS_W-1:0];
      if (s_tvalid && s_tready)
        rotated_q.push_back(rotate_vector(s_tdata, eps_reg));
      if (m_tvalid && m_tready) begin
        rotated_count <= rotated_count + 1;
        if (m_tuser[0]) short_count <= short_count + 1;
        if (rotated_q.size() == 0) begin
          $error("result with nothing expected: %h/%b", m_tdata, m_tuser);
          errs++;
        end else begin
          want = rotated_q.pop_front();
          if (m_tdata[15:0] !== want.x) begin
            $error("out_x expected %h actual %h", want.x, m_tdata[15:0]);
            errs++;
          end
          if (m_tdata[31:16] !== want.y) begin
            $error("out_y expected %h actual %h", want.y, m_tdata[31:16]);
            errs++;
          end
          if (m_tdata[47:32] !== want.z) begin
            $error("out_z expected %h actual %h", want.z, m_tdata[47:32]);
            errs++;
          end
          if (m_tuser[0] !== want.short_q) begin
            $error("too_short expected %b actual %b", want.short_q, m_tuser[0]);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

FILE: bench/tb_quaternion_vector_rotate_core.sv
`timescale 1ns / 1ps

module tb_quaternion_vector_rotate_core;
  import qvr_pkg::*;

  localparam int LATENCY   = 25;
  localparam int STALL_MAX = 5000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_DW-1:0]   m_tdata;
  logic [0:0]          m_tuser;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  int                  fail_count, pending_count, rotated_count, short_count;
  int                  idle_cycles = 0;
  int                  sent_count = 0;
  bit                  no_gaps = 1'b0;

  always #6 clk_i = ~clk_i;

  quaternion_vector_rotate_core DUT (.*);

  qvr_rotation_checker u_checker (.*);

  always @(posedge clk_i) begin
    if (rst_ni) m_tready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 25);
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_MAX) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_epsilon(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'd0;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    while (pending_count != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic send_rotation(logic [IN_W-1:0] d);
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < 25) begin
        s_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sent_count++;
  endtask

  function automatic logic [15:0] pick_comp(int mode);
    case (mode)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 32)) - 16);
      3: return 16'($urandom_range(0, 16384));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [IN_W-1:0] random_rotation();
    logic [IN_W-1:0] d;
    int m;
    m = $urandom_range(0, 9);
    for (int i = 0; i < 7; i++)
      d[16*i +: 16] = (m < 7) ? 16'($urandom) : pick_comp($urandom_range(0, 4));
    // near-unit quaternion for part of the draws; the vector stays as drawn
    if (m < 4) begin
      d[15:0]  = 16'($urandom_range(8000, 16384));
      d[31:16] = 16'($signed($urandom_range(0, 16000)) - 8000);
      d[47:32] = 16'($signed($urandom_range(0, 16000)) - 8000);
      d[63:48] = 16'($signed($urandom_range(0, 16000)) - 8000);
    end
    return d;
  endfunction

  initial begin
    logic [IN_W-1:0] d;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: identity, zero, extremes, short and almost-short quaternions, a quarter turn about z
    send_rotation({16'h0100, 16'h0200, 16'h0300, 16'h0000, 16'h0000, 16'h0000, 16'h4000});
    send_rotation({16'h7fff, 16'h8000, 16'h1234, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_rotation({16'h7fff, 16'h7fff, 16'h7fff, {4{16'h7fff}}});
    send_rotation({16'h8000, 16'h8000, 16'h8000, {4{16'h8000}}});
    send_rotation({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
    send_rotation({16'h0100, 16'h0100, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0001});
    send_rotation({16'h0100, 16'h0100, 16'h0100, 16'h0000, 16'h0000, 16'h0001, 16'h0001});
    send_rotation({16'h0100, 16'hff00, 16'h0080, 16'h2d41, 16'h0000, 16'h0000, 16'h2d41});
    send_rotation({16'hffff, 16'h0001, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff});
    send_rotation({16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555});
    s_tvalid <= 1'b0;
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_epsilon(32'h0000_0000);
        1: write_epsilon(32'h0000_7fff);
        2: write_epsilon(32'hffff_8000 | 32'($urandom_range(0, 40)));
        3: write_epsilon(32'($urandom_range(8000, 20000)));
        default: write_epsilon(32'd1);
      endcase
      if (phase == 1)
        send_rotation({16'h0100, 16'h0100, 16'h0100, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
      no_gaps = (phase == 3);
      for (int k = 0; k < 140; k++) begin
        d = random_rotation();
        if (phase == 2 && k % 4 == 0) d[63:0] = {4{16'($signed($urandom_range(0, 40)) - 20)}};
        send_rotation(d);
        // hold input until everything has come back
        if (phase == 4 && k == 70) begin
          s_tvalid <= 1'b0;
          while (pending_count != 0) @(posedge clk_i);
        end
      end
      s_tvalid <= 1'b0;
      no_gaps = 1'b0;
      drain();
    end

    $display("rotated %0d transactions (%0d with a short quaternion) over five epsilon settings",
             rotated_count, short_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
